>>> src/max_pool_5x5_same_top_defines.svh
`ifndef MAX_POOL_5X5_SAME_TOP_DEFINES_SVH
`define MAX_POOL_5X5_SAME_TOP_DEFINES_SVH

// concurrent check, quiet while reset is held
`define MP5_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs during reset
`define MP5_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/mp5_pkg.sv
`default_nettype none

package mp5_pkg;

    localparam int MAX_WIDTH    = 64;
    localparam int MAX_HEIGHT   = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int PIX_W        = 8;
    localparam int LINE_ROWS    = 4;
    localparam int SLOT_W       = $clog2(LINE_ROWS);
    localparam int WORD_W       = LINE_ROWS * PIX_W;
    localparam int WIN          = 5;
    localparam int HALF         = 2;
    localparam int OFF_W        = 2;
    localparam int WIDTH_REG_W  = 7;
    localparam int HEIGHT_REG_W = 11;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 11;

    localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT = CFG_IDX_W'(1);

    typedef logic signed [PIX_W-1:0] pix_t;

    localparam pix_t PIX_MIN = -8'sd128;

    // one column as it leaves the line-store stage
    typedef struct packed {
        logic                       has_out;
        logic                       last_row;
        logic                       last_col;
        logic [OFF_W-1:0]           dy_hi;
        logic [OFF_W-1:0]           dx_hi;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic [HALF:0][PIX_W-1:0]   cmax;
    } mp5_push_t;

    function automatic pix_t pix_max(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

>>> src/mp5_emit.sv
`default_nettype none

module mp5_emit import mp5_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mp5_push_t           push_info,
    output logic                run_free,
    input  logic                out_ready,
    output logic                out_valid,
    output logic signed [7:0]   pixel_out,
    output logic [ROW_W-1:0]    out_row,
    output logic [COL_W-1:0]    out_col,
    output logic                last_of_run,
    output logic                end_of_plane
);

    // column maxima of the last five columns, index 0 newest, one per vertical offset
    logic [WIN-1:0][HALF:0][PIX_W-1:0] cm_reg, cm_next;

    logic               run_valid_reg, run_valid_next;
    logic [ROW_W-1:0]   run_row_reg, run_row_next;
    logic [COL_W-1:0]   run_col_reg, run_col_next;
    logic               run_last_row_reg, run_last_row_next;
    logic               run_last_col_reg, run_last_col_next;
    logic [OFF_W-1:0]   dy_reg, dy_next;
    logic [OFF_W-1:0]   dx_reg, dx_next;
    logic [OFF_W-1:0]   dx_hi_reg, dx_hi_next;

    logic               out_valid_reg, out_valid_next;
    pix_t               out_pix_reg, out_pix_next;
    logic [ROW_W-1:0]   out_row_reg, out_row_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic               out_last_reg, out_last_next;
    logic               out_eop_reg, out_eop_next;

    logic [OFF_W-1:0]   dy_lo;
    logic [OFF_W-1:0]   dx_lo;
    logic               run_last;
    logic               gen_fire;
    pix_t               hmax;

    assign dy_lo    = run_last_row_reg ? '0 : OFF_W'(HALF);
    assign dx_lo    = run_last_col_reg ? '0 : OFF_W'(HALF);
    assign run_last = (dy_reg == dy_lo) && (dx_reg == dx_lo);
    assign gen_fire = run_valid_reg && (!out_valid_reg || out_ready);
    assign run_free = !run_valid_reg || (gen_fire && run_last);

    // horizontal max, clipped at the row start
    always_comb
    begin
        hmax = PIX_MIN;
        for (int e = 0; e < WIN; e++)
        begin
            if (((OFF_W + 1)'(e) <= (OFF_W + 1)'(dx_reg) + (OFF_W + 1)'(HALF)) &&
                (run_col_reg >= COL_W'(e)))
            begin
                hmax = pix_max(hmax, pix_t'(cm_reg[e][dy_reg]));
            end
        end
    end

    always_comb
    begin
        cm_next           = cm_reg;
        run_valid_next    = run_valid_reg;
        run_row_next      = run_row_reg;
        run_col_next      = run_col_reg;
        run_last_row_next = run_last_row_reg;
        run_last_col_next = run_last_col_reg;
        dy_next           = dy_reg;
        dx_next           = dx_reg;
        dx_hi_next        = dx_hi_reg;

        if (gen_fire)
        begin
            if (dx_reg != dx_lo)
            begin
                dx_next = dx_reg - OFF_W'(1);
            end
            else
            begin
                dx_next = dx_hi_reg;
                dy_next = dy_reg - OFF_W'(1);
            end
            if (run_last)
            begin
                run_valid_next = 1'b0;
            end
        end

        if (push)
        begin
            cm_next           = {cm_reg[WIN-2:0], push_info.cmax};
            run_valid_next    = push_info.has_out;
            run_row_next      = push_info.row;
            run_col_next      = push_info.col;
            run_last_row_next = push_info.last_row;
            run_last_col_next = push_info.last_col;
            dy_next           = push_info.dy_hi;
            dx_next           = push_info.dx_hi;
            dx_hi_next        = push_info.dx_hi;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_pix_next   = out_pix_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;
        out_eop_next   = out_eop_reg;
        if (gen_fire)
        begin
            out_valid_next = 1'b1;
            out_pix_next   = hmax;
            out_row_next   = run_row_reg - ROW_W'(dy_reg);
            out_col_next   = run_col_reg - COL_W'(dx_reg);
            out_last_next  = run_last;
            out_eop_next   = run_last_row_reg && run_last_col_reg &&
                             (dy_reg == '0) && (dx_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_valid_reg <= run_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cm_reg           <= cm_next;
        run_row_reg      <= run_row_next;
        run_col_reg      <= run_col_next;
        run_last_row_reg <= run_last_row_next;
        run_last_col_reg <= run_last_col_next;
        dy_reg           <= dy_next;
        dx_reg           <= dx_next;
        dx_hi_reg        <= dx_hi_next;
        out_pix_reg      <= out_pix_next;
        out_row_reg      <= out_row_next;
        out_col_reg      <= out_col_next;
        out_last_reg     <= out_last_next;
        out_eop_reg      <= out_eop_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_out    = out_pix_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign last_of_run  = out_last_reg;
    assign end_of_plane = out_eop_reg;

endmodule

`default_nettype wire

>>> src/max_pool_5x5_same_top.sv
// 5x5 stride-1 max filter, window centered, clipped at the plane border.
// cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
//   plane_width, index 1 plane_height, other indexes are ignored. cfg_ready
//   is always high. write only while no beat is in flight.
// input channel: in_valid/in_ready, one pixel_in beat per pixel, raster order.
// output channel: out_valid/out_ready with pixel_out, out_row, out_col,
//   last_of_run (final result caused by one input beat) and end_of_plane.
// path: the input beat that completes a window is registered in the line-store
//   stage, then in the generator's run registers, then in the output register.
// throughput: one input beat per cycle while out_ready holds high and each pixel
//   yields at most one result; a row end yields up to three results and the plane's
//   last pixel up to nine, and the input side waits out the extra results. the rate
//   is set by the single result generator, one window max per cycle unless stalled.
// the line store is one 64 x 32 word ram holding four rows per column; each
//   beat reads its column on acceptance and writes it back as it leaves the
//   line-store stage, with forwarding when the next beat hits the same column.
// reset: position returns to row 0 col 0, width and height go to 40, the
//   pipeline empties; the ram is not cleared.
// stall: while out_ready is low the output register holds its beat, the
//   pipeline keeps at most one pending beat per stage and in_ready drops once they fill.
`default_nettype none

module max_pool_5x5_same_top import mp5_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [7:0]       pixel_in,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [7:0]       pixel_out,
    output logic [ROW_W-1:0]        out_row,
    output logic [COL_W-1:0]        out_col,
    output logic                    last_of_run,
    output logic                    end_of_plane
);

    // configuration
    logic [WIDTH_REG_W-1:0]  width_reg, width_next;
    logic [HEIGHT_REG_W-1:0] height_reg, height_next;

    // position of the next pixel
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    // line-store stage: pixel waiting for its column word
    logic               s1_valid_reg, s1_valid_next;
    pix_t               s1_pixel_reg, s1_pixel_next;
    logic [ROW_W-1:0]   s1_row_reg, s1_row_next;
    logic [COL_W-1:0]   s1_col_reg, s1_col_next;
    logic               s1_last_row_reg, s1_last_row_next;
    logic               s1_last_col_reg, s1_last_col_next;

    // line store: one word per column, byte (row mod 4) holds that row
    logic [WORD_W-1:0]  line_mem [MAX_WIDTH];
    logic [WORD_W-1:0]  rdata_reg;
    logic [WORD_W-1:0]  wdata;

    logic [WIDTH_REG_W-1:0]  w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic                    out_of_plane;
    logic [ROW_W-1:0]        acc_row;
    logic [COL_W-1:0]        acc_col;
    logic [WIDTH_REG_W-1:0]  col_inc;
    logic [HEIGHT_REG_W-1:0] row_inc;
    logic                    accept;
    logic                    s1_adv;
    logic                    fwd;
    logic                    run_free;

    pix_t                    vals [WIN];
    pix_t                    vmax [WIN];
    mp5_push_t               push_info;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PLANE_WIDTH:  width_next  = cfg_data[WIDTH_REG_W-1:0];
                REG_PLANE_HEIGHT: height_next = cfg_data[HEIGHT_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    // register values clamped to the supported plane
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WIDTH_REG_W'(1);
        else if (width_reg > WIDTH_REG_W'(MAX_WIDTH))
            w_eff = WIDTH_REG_W'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = HEIGHT_REG_W'(1);
        else if (height_reg > HEIGHT_REG_W'(MAX_HEIGHT))
            h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // a position left outside a shrunk plane restarts the plane
    assign out_of_plane = (HEIGHT_REG_W'(row_reg) >= h_eff) ||
                          (WIDTH_REG_W'(col_reg) >= w_eff);
    assign acc_row = out_of_plane ? '0 : row_reg;
    assign acc_col = out_of_plane ? '0 : col_reg;
    assign col_inc = WIDTH_REG_W'(acc_col) + WIDTH_REG_W'(1);
    assign row_inc = HEIGHT_REG_W'(acc_row) + HEIGHT_REG_W'(1);

    // the stage moves on whenever the generator can take its column
    assign s1_adv   = s1_valid_reg && run_free;
    assign in_ready = !s1_valid_reg || run_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
                row_next = acc_row;
            end
        end
    end

    always_comb
    begin
        s1_valid_next    = s1_valid_reg && !s1_adv;
        s1_pixel_next    = s1_pixel_reg;
        s1_row_next      = s1_row_reg;
        s1_col_next      = s1_col_reg;
        s1_last_row_next = s1_last_row_reg;
        s1_last_col_next = s1_last_col_reg;
        if (accept)
        begin
            s1_valid_next    = 1'b1;
            s1_pixel_next    = pixel_in;
            s1_row_next      = acc_row;
            s1_col_next      = acc_col;
            s1_last_row_next = HEIGHT_REG_W'(acc_row) == h_eff - HEIGHT_REG_W'(1);
            s1_last_col_next = WIDTH_REG_W'(acc_col) == w_eff - WIDTH_REG_W'(1);
        end
    end

    // write-back word: the oldest row of this column gives way to the new pixel
    always_comb
    begin
        wdata = rdata_reg;
        wdata[PIX_W * s1_row_reg[SLOT_W-1:0] +: PIX_W] = s1_pixel_reg;
    end

    // the next beat reads the column being written back at the same edge
    assign fwd = s1_adv && (s1_col_reg == acc_col);

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            line_mem[s1_col_reg] <= wdata;
        if (accept)
            rdata_reg <= fwd ? wdata : line_mem[acc_col];
    end

    // column values, offset d is row r-d; rows above the plane read as the minimum
    always_comb
    begin
        vals[0] = s1_pixel_reg;
        for (int d = 1; d < WIN; d++)
        begin
            if (s1_row_reg >= ROW_W'(d))
                vals[d] = pix_t'(rdata_reg[PIX_W * (s1_row_reg[SLOT_W-1:0] - SLOT_W'(d))
                                           +: PIX_W]);
            else
                vals[d] = PIX_MIN;
        end
    end

    // running max down the column; the window of row r-dy spans offsets up to dy+2
    always_comb
    begin
        vmax[0] = vals[0];
        for (int d = 1; d < WIN; d++)
        begin
            vmax[d] = pix_max(vmax[d-1], vals[d]);
        end
    end

    always_comb
    begin
        push_info.has_out  = (s1_last_row_reg || (s1_row_reg >= ROW_W'(HALF))) &&
                             (s1_last_col_reg || (s1_col_reg >= COL_W'(HALF)));
        push_info.last_row = s1_last_row_reg;
        push_info.last_col = s1_last_col_reg;
        push_info.dy_hi    = (s1_row_reg >= ROW_W'(HALF)) ? OFF_W'(HALF)
                                                          : s1_row_reg[OFF_W-1:0];
        push_info.dx_hi    = (s1_col_reg >= COL_W'(HALF)) ? OFF_W'(HALF)
                                                          : s1_col_reg[OFF_W-1:0];
        push_info.row      = s1_row_reg;
        push_info.col      = s1_col_reg;
        for (int dy = 0; dy <= HALF; dy++)
        begin
            push_info.cmax[dy] = vmax[dy + HALF];
        end
    end

    mp5_emit u_emit
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (s1_adv),
        .push_info    (push_info),
        .run_free     (run_free),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .pixel_out    (pixel_out),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_run  (last_of_run),
        .end_of_plane (end_of_plane)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_REG_W'(40);
            height_reg   <= HEIGHT_REG_W'(40);
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pixel_reg    <= s1_pixel_next;
        s1_row_reg      <= s1_row_next;
        s1_col_reg      <= s1_col_next;
        s1_last_row_reg <= s1_last_row_next;
        s1_last_col_reg <= s1_last_col_next;
    end

endmodule

`default_nettype wire

>>> src/mp5_checker.sv
`default_nettype none
`include "max_pool_5x5_same_top_defines.svh"

module mp5_checker import mp5_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic signed [7:0]    pixel_out,
    input logic [ROW_W-1:0]     out_row,
    input logic [COL_W-1:0]     out_col,
    input logic                 last_of_run,
    input logic                 end_of_plane
);

    // nothing is offered while reset is held
    `MP5_ASSERT_ALWAYS(a_reset_quiet, (!rst_n |-> !out_valid), "output valid during reset")

    // a stalled result beat holds
    `MP5_ASSERT(a_out_hold, ((out_valid && !out_ready) |=> (out_valid && $stable(pixel_out) && $stable(out_row) && $stable(out_col) && $stable(last_of_run) && $stable(end_of_plane))), "stalled result changed")

    // the rest of a run follows without a gap
    `MP5_ASSERT(a_run_gapless, ((out_valid && out_ready && !last_of_run) |=> out_valid), "gap inside a run of results")

    // results of one run come in raster order
    `MP5_ASSERT(a_run_raster, ((out_valid && out_ready && !last_of_run) |=> ((out_row == $past(out_row) && out_col == $past(out_col) + 1'b1) || (out_row == $past(out_row) + 1'b1))), "run out of raster order")

endmodule

bind max_pool_5x5_same_top mp5_checker u_checker (.*);

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mp5_pkg::*;

    // run shape
    localparam int RANDOM_PIXELS_PER_PHASE = 110;
    localparam int BURST_CAP               = 120;
    localparam int SETTLE_CYCLES           = 8;     // output register sits behind the line-store and run registers
    localparam int STALL_LIMIT             = 3000;
    localparam int REPORT_CAP              = 30;
    localparam int RESET_CYCLES            = 6;
    localparam int RESET_PLANE_SIZE        = 40;
    localparam int STORE_DEPTH             = LINE_ROWS * MAX_WIDTH;

    // top register index, ignored by the block like every index past height
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = '1;

    localparam pix_t PIX_TOP = 8'sd127;

    // one result beat as the block should present it
    typedef struct packed {
        pix_t               level;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               last_of_run;
        logic               end_of_plane;
    } pooled_t;

    localparam pooled_t NO_RESULT = '0;

    typedef enum logic {STEP_REG, STEP_PIXEL} step_kind_e;

    // one row of the directed table; want is used only where typed is set
    typedef struct packed {
        step_kind_e                 kind;
        logic [CFG_IDX_W-1:0]       index;
        logic [CFG_DATA_W-1:0]      data;
        pix_t                       px;
        logic                       typed;
        pooled_t                    want;
    } step_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [7:0]          pixel_in;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [7:0]          pixel_out;
    logic [ROW_W-1:0]           out_row;
    logic [COL_W-1:0]           out_col;
    logic                       last_of_run;
    logic                       end_of_plane;

    // mirror of the block: registers, line store, row-four-above history, position
    logic [WIDTH_REG_W-1:0]     plane_w_reg;
    logic [HEIGHT_REG_W-1:0]    plane_h_reg;
    pix_t                       line_px [STORE_DEPTH];
    pix_t                       aged_px [WIN];
    int                         at_row;
    int                         at_col;

    // windows still owed by the block, oldest first
    pooled_t                    pooled_expected [$];

    int                         send_idle_pct;
    int                         recv_idle_pct;
    int                         mismatch_count;
    int                         pixels_sent;
    int                         pooled_seen;
    int                         reg_writes;

    step_t                      directed_plan [38];

    max_pool_5x5_same_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_in     (pixel_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_out    (pixel_out),
        .out_row      (out_row),
        .out_col      (out_col),
        .last_of_run  (last_of_run),
        .end_of_plane (end_of_plane)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // pooling predictor
    // ------------------------------------------------------------------

    // register value to the width actually used, 0 reads as 1
    function automatic int usable_width(input int raw);
        if (raw < 1)
            return 1;
        if (raw > MAX_WIDTH)
            return MAX_WIDTH;
        return raw;
    endfunction

    function automatic int usable_height(input int raw);
        if (raw < 1)
            return 1;
        if (raw > MAX_HEIGHT)
            return MAX_HEIGHT;
        return raw;
    endfunction

    // pixel (iy, ix) as seen while pixel (r, c) goes in; row r-4 was just
    // overwritten in the store, so it comes from the saved history
    function automatic int stored_at(input int iy, input int ix, input int r, input int c);
        int k;
        if (iy + 4 == r)
        begin
            k = c - ix;
            return (k < WIN) ? int'(aged_px[k]) : 0;
        end
        return int'(line_px[(iy % LINE_ROWS) * MAX_WIDTH + (ix % MAX_WIDTH)]);
    endfunction

    // max over the window centered on (oy, ox), clipped to the plane
    function automatic int window_peak(input int oy, input int ox, input int r, input int c,
                                       input int h, input int w);
        int best;
        int y0;
        int y1;
        int x0;
        int x1;
        int v;
        best = int'(PIX_MIN);
        y0 = (oy >= HALF) ? oy - HALF : 0;
        y1 = (oy + HALF < h) ? oy + HALF : h - 1;
        x0 = (ox >= HALF) ? ox - HALF : 0;
        x1 = (ox + HALF < w) ? ox + HALF : w - 1;
        for (int iy = y0; iy <= y1; iy++)
            for (int ix = x0; ix <= x1; ix++)
            begin
                v = stored_at(iy, ix, r, c);
                if (v > best)
                    best = v;
            end
        return best;
    endfunction

    // take one pixel beat, queue every window it completes in raster order
    task automatic predict_pooled(input pix_t px, output int made);
        int      w;
        int      h;
        int      r;
        int      c;
        int      slot;
        int      oy0;
        int      oy1;
        int      ox0;
        int      ox1;
        pooled_t res;
        w = usable_width(int'(plane_w_reg));
        h = usable_height(int'(plane_h_reg));
        made = 0;
        // registers moved under the position: start over with this pixel
        if (at_row >= h || at_col >= w)
        begin
            at_row = 0;
            at_col = 0;
        end
        r = at_row;
        c = at_col;
        slot = (r % LINE_ROWS) * MAX_WIDTH + c;
        for (int k = WIN - 1; k > 0; k--)
            aged_px[k] = aged_px[k-1];
        aged_px[0] = line_px[slot];
        line_px[slot] = px;

        if (r == h - 1)
        begin
            oy0 = (r >= HALF) ? r - HALF : 0;
            oy1 = r;
        end
        else if (r >= HALF)
        begin
            oy0 = r - HALF;
            oy1 = r - HALF;
        end
        else
        begin
            oy0 = 1;
            oy1 = 0;
        end
        if (c == w - 1)
        begin
            ox0 = (c >= HALF) ? c - HALF : 0;
            ox1 = c;
        end
        else if (c >= HALF)
        begin
            ox0 = c - HALF;
            ox1 = c - HALF;
        end
        else
        begin
            ox0 = 1;
            ox1 = 0;
        end

        for (int oy = oy0; oy <= oy1; oy++)
            for (int ox = ox0; ox <= ox1; ox++)
            begin
                res.level        = pix_t'(window_peak(oy, ox, r, c, h, w));
                res.row          = ROW_W'(oy);
                res.col          = COL_W'(ox);
                res.last_of_run  = 1'b0;
                res.end_of_plane = (oy == h - 1) && (ox == w - 1);
                pooled_expected.push_back(res);
                made++;
            end
        if (made > 0)
            pooled_expected[pooled_expected.size() - 1].last_of_run = 1'b1;

        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        at_row = r;
        at_col = c;
    endtask

    // ------------------------------------------------------------------
    // directed table rows
    // ------------------------------------------------------------------

    function automatic step_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        step_t s;
        s = '0;
        s.kind  = STEP_REG;
        s.index = idx;
        s.data  = data;
        return s;
    endfunction

    function automatic step_t pix_row(input pix_t px);
        step_t s;
        s = '0;
        s.kind = STEP_PIXEL;
        s.px   = px;
        return s;
    endfunction

    // pixel whose single result is known by inspection
    function automatic step_t checked_row(input pix_t px, input pix_t level, input int row,
                                          input int col, input logic last, input logic eop);
        step_t s;
        s = pix_row(px);
        s.typed                  = 1'b1;
        s.want.level             = level;
        s.want.row               = ROW_W'(row);
        s.want.col               = COL_W'(col);
        s.want.last_of_run       = last;
        s.want.end_of_plane      = eop;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // drop the pixel stream and let every owed result come out
    task automatic settle();
        in_valid <= 1'b0;
        while (pooled_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only ever issued with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_PLANE_WIDTH)
            plane_w_reg = data[WIDTH_REG_W-1:0];
        else if (idx == REG_PLANE_HEIGHT)
            plane_h_reg = data[HEIGHT_REG_W-1:0];
        reg_writes++;
    endtask

    // one pixel beat; valid stays up across back-to-back beats
    task automatic push_pixel(input pix_t px, input logic typed, input pooled_t want);
        int made;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        pixel_in <= px;
        do @(posedge clk); while (!in_ready);
        predict_pooled(px, made);
        // typed rows replace what the predictor queued for this beat
        if (typed)
        begin
            repeat (made) void'(pooled_expected.pop_back());
            pooled_expected.push_back(want);
        end
        pixels_sent++;
    endtask

    // lean toward the floor and the ceiling, since padding sits at the floor
    function automatic pix_t pick_pixel();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 15)
            return PIX_MIN;
        if (sel < 25)
            return PIX_TOP;
        if (sel < 45)
            return pix_t'($urandom_range(0, 7) + int'(PIX_MIN));
        return pix_t'($urandom);
    endfunction

    // random planes: pick a shape, write it, stream a full or partial plane.
    // a partial plane leaves the next shape landing mid-plane; a wider plane
    // is refused there, since stored rows would then be read past what this
    // plane wrote
    task automatic run_random_planes(input int budget);
        int                     sent;
        int                     sel;
        int                     w_raw;
        int                     h_raw;
        int                     new_w;
        int                     new_h;
        int                     remaining;
        int                     n;
        logic [CFG_DATA_W-1:0]  wdata;
        sent = 0;
        while (sent < budget)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
            begin
                w_raw = $urandom_range(1, 8);
                h_raw = $urandom_range(1, 8);
            end
            else if (sel < 80)
            begin
                w_raw = $urandom_range(0, (1 << WIDTH_REG_W) - 1);
                h_raw = $urandom_range(0, 3);
            end
            else
            begin
                w_raw = $urandom_range(0, 3);
                h_raw = $urandom_range(0, (1 << HEIGHT_REG_W) - 1);
            end
            new_w = usable_width(w_raw);
            new_h = usable_height(h_raw);
            if ((at_row != 0 || at_col != 0) && at_row < new_h && at_col < new_w &&
                new_w > usable_width(int'(plane_w_reg)))
            begin
                w_raw = int'(plane_w_reg);
                new_w = usable_width(w_raw);
            end

            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_IDX_W'($urandom_range(int'(REG_PLANE_HEIGHT) + 1,
                                                    int'(REG_INDEX_TOP))),
                          CFG_DATA_W'($urandom));
            // bits above the width field ride along and must be dropped
            wdata = CFG_DATA_W'($urandom);
            wdata[WIDTH_REG_W-1:0] = WIDTH_REG_W'(w_raw);
            write_reg(REG_PLANE_WIDTH, wdata);
            write_reg(REG_PLANE_HEIGHT, CFG_DATA_W'(h_raw));

            if (at_row >= new_h || at_col >= new_w)
                remaining = new_w * new_h;
            else
                remaining = new_w * new_h - (at_row * new_w + at_col);
            n = remaining;
            if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, n);
            if (n > BURST_CAP)
                n = $urandom_range(1, BURST_CAP);
            repeat (n) push_pixel(pick_pixel(), 1'b0, NO_RESULT);
            sent += n;
        end
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic compare_field(input string what, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
                $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    // every accepted result beat against the oldest owed window
    always @(posedge clk)
    begin
        pooled_t want;
        if (rst_n && out_valid && out_ready)
        begin
            pooled_seen++;
            if (pooled_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_CAP)
                    $display("%0t: result beat expected none actual row %0d col %0d value %0d",
                             $time, out_row, out_col, pixel_out);
            end
            else
            begin
                want = pooled_expected.pop_front();
                compare_field("pixel_out", want.level, pixel_out);
                compare_field("out_row", want.row, out_row);
                compare_field("out_col", want.col, out_col);
                compare_field("last_of_run", want.last_of_run, last_of_run);
                compare_field("end_of_plane", want.end_of_plane, end_of_plane);
            end
        end
    end

    // watchdog: too long with no beat on any channel ends the run
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout after %0d quiet cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        pixel_in  <= '0;
        out_ready <= 1'b0;

        // mirror comes up like the block after reset
        plane_w_reg = WIDTH_REG_W'(RESET_PLANE_SIZE);
        plane_h_reg = HEIGHT_REG_W'(RESET_PLANE_SIZE);
        foreach (line_px[i])
            line_px[i] = '0;
        foreach (aged_px[i])
            aged_px[i] = '0;
        at_row = 0;
        at_col = 0;
        mismatch_count = 0;
        pixels_sent    = 0;
        pooled_seen    = 0;
        reg_writes     = 0;

        // first mix: slow sender, choked receiver
        send_idle_pct = 14;
        recv_idle_pct = 84;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        directed_plan = '{
            // one-pixel plane: the window is the pixel itself
            reg_row(REG_PLANE_WIDTH, 11'd1),
            reg_row(REG_PLANE_HEIGHT, 11'd1),
            checked_row(PIX_TOP, PIX_TOP, 0, 0, 1'b1, 1'b1),
            checked_row(PIX_MIN, PIX_MIN, 0, 0, 1'b1, 1'b1),
            // narrower than the window, two rows: six results on the last pixel
            reg_row(REG_PLANE_WIDTH, 11'd3),
            reg_row(REG_PLANE_HEIGHT, 11'd2),
            pix_row(PIX_MIN), pix_row(PIX_TOP), pix_row(8'sd0),
            pix_row(-8'sd1), pix_row(8'sd1), pix_row(PIX_MIN),
            // 5 wide, height cut to 3 mid-plane with the position still inside
            reg_row(REG_PLANE_WIDTH, 11'd5),
            reg_row(REG_PLANE_HEIGHT, 11'd8),
            pix_row(8'sd3), pix_row(PIX_MIN), pix_row(PIX_TOP), pix_row(-8'sd7),
            pix_row(8'sd64), pix_row(-8'sd100), pix_row(8'sd12),
            reg_row(REG_PLANE_HEIGHT, 11'd3),
            pix_row(-8'sd50), pix_row(8'sd99), pix_row(PIX_MIN),
            // width narrowed at the start of the last row, full nine at the end
            reg_row(REG_PLANE_WIDTH, 11'd4),
            pix_row(8'sd0), pix_row(-8'sd1), pix_row(8'sd126), pix_row(-8'sd127),
            // width field zero under set upper bits, height at the top code
            reg_row(REG_PLANE_WIDTH, 11'h780),
            reg_row(REG_PLANE_HEIGHT, 11'h7FF),
            pix_row(PIX_TOP), pix_row(PIX_MIN), pix_row(8'sd5),
            // height zero leaves the position past the plane: restart here
            reg_row(REG_PLANE_HEIGHT, 11'd0),
            checked_row(-8'sd1, -8'sd1, 0, 0, 1'b1, 1'b1),
            // unused index, must change nothing
            reg_row(REG_INDEX_TOP, 11'h7FF)
        };

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == STEP_REG)
                write_reg(directed_plan[i].index, directed_plan[i].data);
            else
                push_pixel(directed_plan[i].px, directed_plan[i].typed,
                           directed_plan[i].want);
        end

        run_random_planes(RANDOM_PIXELS_PER_PHASE);

        // second mix: sparse sender, eager receiver
        send_idle_pct = 84;
        recv_idle_pct = 14;
        run_random_planes(RANDOM_PIXELS_PER_PHASE);

        // third mix: full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_planes(RANDOM_PIXELS_PER_PHASE);

        settle();

        $display("pooled %0d pixel beats into %0d result beats across %0d register writes",
                 pixels_sent, pooled_seen, reg_writes);
        $display("shapes from one pixel to clamped width and height, mid-plane changes, "
                 , "three handshake duty mixes");
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
